[hdl/erlb_pkg.sv]
// Shared constants, types and control structures of the event rate limiter.
`timescale 1ns / 1ps

package erlb_pkg;

    localparam int CountBits  = 32;
    localparam int CmpBits    = (CountBits > 16) ? CountBits : 16;
    localparam int ExtBits    = (CountBits > 32) ? CountBits : 32;
    localparam int CfgBits    = 17;
    localparam int CfgIdxBits = 2;
    localparam int SkipBits   = 17;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_REACT_LIMIT       = 2'd0,
        CFG_WINDOW_SECONDS    = 2'd1,
        CFG_PRESCALE_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WINDOW,
        ST_DECIDE,
        ST_BACKOFF,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic window_step;
        logic decide;
        logic sc_start;
        logic backoff_done;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic need_backoff;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic done;
        logic hit;
    } t_sc_status;

endpackage

[hdl/event_rate_limiter_backoff_top.sv]
// Top level of the event rate limiter with exponential backoff.
`timescale 1ns / 1ps

// Usage: each input transaction carries one event timestamp in seconds on
// i_event_time, handshaked by i_in_valid and o_in_ready. Each event yields
// exactly one output transaction on o_out_valid and i_out_ready with the react
// flag, the window count and the total count after this event.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while
// the block is idle. Index 0 is the reaction limit, index 1 the idle window in
// seconds and index 2 the prescale interval; other indexes are ignored.
// Sequence: an accepted event passes through the window, decide and output
// states, and the result is loaded into the output register in the output
// state before the idle state accepts the next event. A search for a window
// count above a positive limit runs in a backoff state between decide and
// output and tests one power of two per cycle.
// The next event is accepted once the previous result sits in the output
// register, even if the receiver has not yet taken it.
// If the receiver stalls, the result waits in the output register and the
// following event stops before its own output load until the slot frees.
// Reset restores the default registers (unlimited reactions, window disabled,
// no prescaling) and clears the previous timestamp, counts and prescaler.

module event_rate_limiter_backoff_top
    import erlb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_event_time,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_react,
    output logic [31:0]           o_window_count,
    output logic [31:0]           o_total_count,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [CfgBits-1:0]    i_cfg_data
);

    logic [16:0]          r_limit;
    logic [16:0]          r_window;
    logic [15:0]          r_interval;
    logic [31:0]          r_time;
    logic [31:0]          r_prev;
    logic [CountBits-1:0] r_win;
    logic [CountBits-1:0] r_total;
    logic [SkipBits-1:0]  r_skip;
    logic                 r_react;
    logic                 r_ovalid;
    logic                 r_oreact;
    logic [31:0]          r_owin;
    logic [31:0]          r_ototal;

    t_ctrl                w_ctrl;
    t_dp_status           w_dp;
    t_sc_status           w_sc;

    logic signed [32:0]   w_elapsed;
    logic signed [32:0]   w_window_ext;
    logic                 w_restart;
    logic [SkipBits-1:0]  w_reload;
    logic [SkipBits-1:0]  w_skip_base;
    logic [CountBits-1:0] w_win_base;
    logic                 w_pass;
    logic                 w_le;
    logic [CountBits-1:0] w_lim_cb;
    logic [ExtBits-1:0]   w_win_ext;
    logic [ExtBits-1:0]   w_total_ext;

    assign w_elapsed    = $signed({1'b0, r_time}) - $signed({1'b0, r_prev});
    assign w_window_ext = $signed({{16{r_window[16]}}, r_window});
    assign w_restart    = !r_window[16] && (w_elapsed >= w_window_ext);
    assign w_reload     = (r_interval == '0) ? '0 : SkipBits'({1'b0, r_interval} - 17'd1);
    assign w_skip_base  = w_restart ? w_reload : r_skip;
    assign w_win_base   = w_restart ? '0 : r_win;

    assign w_pass   = (r_skip >= {1'b0, r_interval}) && (r_limit != '0);
    assign w_le     = CmpBits'(r_win) <= CmpBits'(r_limit[15:0]);
    assign w_lim_cb = CountBits'(r_limit[15:0]);

    assign w_dp.need_backoff = w_pass && !r_limit[16] && !w_le;
    assign w_dp.out_free     = !r_ovalid || i_out_ready;

    assign w_win_ext   = ExtBits'(r_win);
    assign w_total_ext = ExtBits'(r_total);

    erlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_dp       (w_dp),
        .i_sc       (w_sc),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    erlb_shcmp u_shcmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_ctrl.sc_start),
        .i_target (r_win - w_lim_cb),
        .i_base   (w_lim_cb),
        .o_status (w_sc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= '1;
            r_window   <= '1;
            r_interval <= '0;
            r_prev     <= '0;
            r_win      <= '0;
            r_total    <= '0;
            r_skip     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_REACT_LIMIT: begin
                        r_limit <= i_cfg_data;
                    end
                    CFG_WINDOW_SECONDS: begin
                        r_window <= i_cfg_data;
                    end
                    CFG_PRESCALE_INTERVAL: begin
                        r_interval <= i_cfg_data[15:0];
                        r_skip     <= (i_cfg_data[15:0] == '0) ? '0
                                      : SkipBits'({1'b0, i_cfg_data[15:0]} - 17'd1);
                    end
                    default: begin
                        r_interval <= r_interval;
                    end
                endcase
            end
            if (w_ctrl.window_step) begin
                r_prev  <= r_time;
                r_win   <= (w_win_base == '1) ? w_win_base : w_win_base + 1'b1;
                r_total <= (r_total == '1) ? r_total : r_total + 1'b1;
                r_skip  <= (w_skip_base == '1) ? w_skip_base : w_skip_base + 1'b1;
            end
            if (w_ctrl.decide && w_pass && (r_limit[16] || w_le)) begin
                r_skip <= '0;
            end
            if (w_ctrl.backoff_done && w_sc.hit) begin
                r_skip <= '0;
            end
            if (w_ctrl.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.capture) begin
            r_time <= i_event_time;
        end
        if (w_ctrl.decide) begin
            r_react <= w_pass && (r_limit[16] || w_le);
        end
        if (w_ctrl.backoff_done) begin
            r_react <= w_sc.hit;
        end
        if (w_ctrl.out_load) begin
            r_oreact <= r_react;
            r_owin   <= w_win_ext[31:0];
            r_ototal <= w_total_ext[31:0];
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_react        = r_oreact;
    assign o_window_count = r_owin;
    assign o_total_count  = r_ototal;

    a_zero_limit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load && (r_limit == '0) |-> !r_react)
        else $error("A zero limit produced a reaction.");

    a_window_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> r_win <= r_total)
        else $error("Window count exceeded total count.");

    a_search_positive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.sc_start |-> !r_limit[16] && (r_limit != '0) && (r_win > w_lim_cb))
        else $error("Backoff search started without a count above a positive limit.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_out_ready |=> r_ovalid)
        else $error("Pending result dropped while the receiver stalled.");

endmodule

[hdl/erlb_shcmp.sv]
// Shift-and-compare unit that tests whether a difference is the limit times a power of two.
`timescale 1ns / 1ps

module erlb_shcmp
    import erlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CountBits-1:0] i_target,
    input  logic [CountBits-1:0] i_base,
    output t_sc_status           o_status
);

    logic                 r_active;
    logic                 n_active;
    logic [CountBits:0]   r_shift;
    logic [CountBits:0]   n_shift;
    logic [CountBits-1:0] r_target;
    logic [CountBits-1:0] n_target;
    logic                 w_eq;
    logic                 w_gt;

    assign w_eq = (r_shift == {1'b0, r_target});
    assign w_gt = (r_shift > {1'b0, r_target});

    assign o_status.done = r_active && (w_eq || w_gt);
    assign o_status.hit  = r_active && w_eq;

    always_comb begin
        n_active = r_active;
        n_shift  = r_shift;
        n_target = r_target;
        if (i_start) begin
            n_active = 1'b1;
            n_shift  = {1'b0, i_base};
            n_target = i_target;
        end else if (r_active) begin
            if (w_eq || w_gt) begin
                n_active = 1'b0;
            end else begin
                n_shift = {r_shift[CountBits-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_shift  <= n_shift;
        r_target <= n_target;
    end

    a_shift_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && !(w_eq || w_gt) |=> !r_shift[CountBits] || o_status.done)
        else $error("Shift register passed the target without stopping.");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_active)
        else $error("Shift-compare unit restarted while busy.");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done && !i_start |=> !r_active)
        else $error("Shift-compare unit stayed active after finishing.");

endmodule

[hdl/erlb_ctrl.sv]
// Sequencer that steps one event through window, decision, backoff search and output.
`timescale 1ns / 1ps

module erlb_ctrl
    import erlb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_dp,
    input  t_sc_status i_sc,
    output logic       o_in_ready,
    output t_ctrl      o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WINDOW;
                end
            end
            ST_WINDOW: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_dp.need_backoff ? ST_BACKOFF : ST_OUT;
            end
            ST_BACKOFF: begin
                if (i_sc.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_dp.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.capture = i_in_valid;
            end
            ST_WINDOW: begin
                o_ctrl.window_step = 1'b1;
            end
            ST_DECIDE: begin
                o_ctrl.decide   = 1'b1;
                o_ctrl.sc_start = i_dp.need_backoff;
            end
            ST_BACKOFF: begin
                o_ctrl.backoff_done = i_sc.done;
            end
            ST_OUT: begin
                o_ctrl.out_load = i_dp.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.capture, o_ctrl.window_step, o_ctrl.decide,
                  o_ctrl.backoff_done, o_ctrl.out_load}))
        else $error("More than one sequencer step active at once.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Sequencer took a second transaction while busy.");

    a_backoff_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BACKOFF && !i_sc.done |=> r_state == ST_BACKOFF)
        else $error("Backoff search left before the unit finished.");

endmodule

[tb/erlb_reaction_checker.sv]
// Checker that predicts the reaction and counts of every event and compares them with the block.
`timescale 1ns / 1ps

module erlb_reaction_checker
    import erlb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [31:0]           i_event_time,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_react,
    input  logic [31:0]           i_window_count,
    input  logic [31:0]           i_total_count,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [CfgBits-1:0]    i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
    localparam logic [SkipBits-1:0] SkipMax = '1;

    typedef struct packed {
        logic        react;
        logic [31:0] window_count;
        logic [31:0] total_count;
    } t_verdict;

    logic signed [CfgBits-1:0] limit_reg;
    logic signed [CfgBits-1:0] window_reg;
    logic [15:0]               interval_reg;
    logic [31:0]               last_stamp;
    logic [31:0]               window_events;
    logic [31:0]               total_events;
    logic [SkipBits-1:0]       skip_run;
    t_verdict                  verdicts[$];
    t_verdict                  want;
    int                        errors = 0;
    int                        results_seen = 0;

    function automatic logic [SkipBits-1:0] skip_reload();
        return (interval_reg != 16'd0) ? {1'b0, interval_reg} - 1'b1 : '0;
    endfunction

    // True when the count above the limit is the limit times a power of two.
    function automatic logic backoff_hit(input logic [31:0] count, input logic [15:0] lim);
        longint unsigned over;
        longint unsigned ratio;
        over = longint'(count) - longint'(lim);
        if (over % lim != 0)
            return 1'b0;
        ratio = over / lim;
        return (ratio != 0) && ((ratio & (ratio - 1)) == 0);
    endfunction

    function automatic t_verdict predict_event(input logic [31:0] stamp);
        t_verdict    v;
        longint      elapsed;
        logic [15:0] lim;
        elapsed = longint'({32'd0, stamp}) - longint'({32'd0, last_stamp});
        lim = limit_reg[15:0];
        if (!window_reg[CfgBits-1] && elapsed >= longint'({48'd0, window_reg[15:0]})) begin
            window_events = '0;
            skip_run = skip_reload();
        end
        last_stamp = stamp;
        if (window_events != CountMax)
            window_events = window_events + 1'b1;
        if (total_events != CountMax)
            total_events = total_events + 1'b1;
        if (skip_run != SkipMax)
            skip_run = skip_run + 1'b1;
        v.react = 1'b0;
        if (skip_run >= {1'b0, interval_reg} && limit_reg != 0) begin
            if (limit_reg[CfgBits-1] || window_events <= {16'd0, lim})
                v.react = 1'b1;
            else
                v.react = backoff_hit(window_events, lim);
            if (v.react)
                skip_run = '0;
        end
        v.window_count = window_events;
        v.total_count = total_events;
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg = '1;
            window_reg = '1;
            interval_reg = '0;
            last_stamp = '0;
            window_events = '0;
            total_events = '0;
            skip_run = '0;
            verdicts.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (verdicts.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Result %0d arrived with no event waiting: react %0b %0d %0d",
                                 results_seen, i_react, i_window_count, i_total_count);
                end else begin
                    want = verdicts.pop_front();
                    if (want.react !== i_react || want.window_count !== i_window_count ||
                        want.total_count !== i_total_count) begin
                        errors++;
                        if (errors <= 10)
                            $display({"Mismatch on result %0d: react %0b/%0b, window_count ",
                                      "%0d/%0d, total_count %0d/%0d (expected/actual)"},
                                     results_seen, want.react, i_react, want.window_count,
                                     i_window_count, want.total_count, i_total_count);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REACT_LIMIT: begin
                        limit_reg = i_cfg_data;
                    end
                    CFG_WINDOW_SECONDS: begin
                        window_reg = i_cfg_data;
                    end
                    CFG_PRESCALE_INTERVAL: begin
                        interval_reg = i_cfg_data[15:0];
                        skip_run = skip_reload();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready)
                verdicts.push_back(predict_event(i_event_time));
        end
        o_fail_count <= errors;
        o_pending <= verdicts.size();
    end

endmodule

[tb/tb_event_rate_limiter_backoff_top.sv]
// Testbench top that drives events and settings into the rate limiter and reports the verdict.
`timescale 1ns / 1ps

module tb_event_rate_limiter_backoff_top;
    import erlb_pkg::*;

    localparam int TimeoutCycles = 600000;
    localparam int SettleCycles = 45;
    localparam int Segments = 12;
    localparam int SegmentEvents = 80;
    localparam logic [CfgIdxBits-1:0] CfgUnusedIdx = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [31:0]           i_event_time;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_react;
    logic [31:0]           o_window_count;
    logic [31:0]           o_total_count;
    logic                  i_cfg_we;
    logic [CfgIdxBits-1:0] i_cfg_index;
    logic [CfgBits-1:0]    i_cfg_data;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          sender_idle = 0;
    int          receiver_stall = 0;
    int          span = 10;
    logic [31:0] stamp_now = '0;

    event_rate_limiter_backoff_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_event_time   (i_event_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_react        (o_react),
        .o_window_count (o_window_count),
        .o_total_count  (o_total_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    erlb_reaction_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_event_time   (i_event_time),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_react        (o_react),
        .i_window_count (o_window_count),
        .i_total_count  (o_total_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TimeoutCycles) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= receiver_stall);
    end

    task automatic send_event(input logic [31:0] stamp);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_event_time = stamp;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            stamp_now = stamp_now + $urandom_range(0, span);
        else if (pick < 68)
            stamp_now = stamp_now - $urandom_range(1, 50);
        else if (pick < 80)
            stamp_now = stamp_now + $urandom_range(span, 4 * span);
        else if (pick < 88)
            stamp_now = $urandom();
        else if (pick < 94)
            stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 100);
        // The remaining picks repeat the previous timestamp.
        return stamp_now;
    endfunction

    task automatic pick_settings();
        int unsigned pick;
        span = $urandom_range(1, 60);
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 10)
                write_reg(CFG_REACT_LIMIT, '1);
            else if (pick < 18)
                write_reg(CFG_REACT_LIMIT, '0);
            else if (pick < 30)
                write_reg(CFG_REACT_LIMIT, 17'd1);
            else if (pick < 55)
                write_reg(CFG_REACT_LIMIT, 17'($urandom_range(2, 6)));
            else if (pick < 70)
                write_reg(CFG_REACT_LIMIT, 17'($urandom_range(7, 40)));
            else if (pick < 78)
                write_reg(CFG_REACT_LIMIT, 17'd65535);
            else if (pick < 88)
                write_reg(CFG_REACT_LIMIT, 17'($urandom_range(41, 300)));
            else
                write_reg(CFG_REACT_LIMIT, 17'($urandom()));
        end
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 20)
                write_reg(CFG_WINDOW_SECONDS, '1);
            else if (pick < 30)
                write_reg(CFG_WINDOW_SECONDS, '0);
            else if (pick < 75)
                write_reg(CFG_WINDOW_SECONDS, 17'($urandom_range(1, 60)));
            else if (pick < 82)
                write_reg(CFG_WINDOW_SECONDS, 17'd65535);
            else if (pick < 90)
                write_reg(CFG_WINDOW_SECONDS, {1'b1, 16'($urandom())});
            else
                write_reg(CFG_WINDOW_SECONDS, 17'($urandom_range(61, 65534)));
        end
        if ($urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 35)
                write_reg(CFG_PRESCALE_INTERVAL, '0);
            else if (pick < 50)
                write_reg(CFG_PRESCALE_INTERVAL, 17'd1);
            else if (pick < 80)
                write_reg(CFG_PRESCALE_INTERVAL, 17'($urandom_range(2, 5)));
            else if (pick < 88)
                write_reg(CFG_PRESCALE_INTERVAL, 17'($urandom_range(6, 30)));
            else if (pick < 93)
                write_reg(CFG_PRESCALE_INTERVAL, 17'd65535);
            else
                write_reg(CFG_PRESCALE_INTERVAL, 17'($urandom()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_event_time = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default settings react to everything, including wrapped and backward timestamps.
        send_event(32'h0000_0000);
        send_event(32'hFFFF_FFFF);
        send_event(32'h0000_0005);
        send_event(32'h8000_0000);

        // A small limit with a short window exercises backoff, restart and time going backwards.
        drain();
        write_reg(CFG_REACT_LIMIT, 17'd2);
        write_reg(CFG_WINDOW_SECONDS, 17'd10);
        write_reg(CFG_PRESCALE_INTERVAL, 17'd0);
        for (int i = 0; i < 6; i++)
            send_event(32'd100 + 32'(i));
        send_event(32'd130);
        send_event(32'd125);

        // A zero window restarts on every event and a zero limit never reacts.
        drain();
        write_reg(CFG_WINDOW_SECONDS, 17'd0);
        write_reg(CFG_REACT_LIMIT, 17'd0);
        send_event(32'd130);
        send_event(32'd131);

        // The most negative window disables it; the largest limit with prescaling.
        drain();
        write_reg(CFG_WINDOW_SECONDS, 17'h10000);
        write_reg(CFG_REACT_LIMIT, 17'd65535);
        write_reg(CFG_PRESCALE_INTERVAL, 17'd3);
        for (int i = 0; i < 4; i++)
            send_event(32'd132 + 32'(i));
        drain();
        write_reg(CFG_PRESCALE_INTERVAL, 17'h10002);
        for (int i = 0; i < 3; i++)
            send_event(32'd136 + 32'(i));

        // An unknown register index must leave the settings alone.
        drain();
        write_reg(CfgUnusedIdx, 17'h1ABCD);
        write_reg(CFG_REACT_LIMIT, 17'd1);
        write_reg(CFG_PRESCALE_INTERVAL, 17'd1);
        write_reg(CFG_WINDOW_SECONDS, 17'd65535);
        send_event(32'd139);
        send_event(32'd140);
        send_event(32'd65675);
        send_event(32'hFFFF_FFFF);
        stamp_now = 32'd1000;

        for (int seg = 0; seg < Segments; seg++) begin
            drain();
            case (seg % 4)
                0: begin
                    sender_idle = 0;
                    receiver_stall = 0;
                end
                1: begin
                    sender_idle = 56;
                    receiver_stall = 0;
                end
                2: begin
                    sender_idle = 0;
                    receiver_stall = 56;
                end
                default: begin
                    sender_idle = 21;
                    receiver_stall = 21;
                end
            endcase
            pick_settings();
            for (int i = 0; i < SegmentEvents; i++)
                send_event(next_stamp());
        end

        drain();
        repeat (SettleCycles) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/erlb_pkg.sv
hdl/erlb_shcmp.sv
hdl/erlb_ctrl.sv
hdl/event_rate_limiter_backoff_top.sv
tb/erlb_reaction_checker.sv
tb/tb_event_rate_limiter_backoff_top.sv
